// ===== rtl/hss_pkg.sv =====
package hss_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int BURST_MAX = 5;
  localparam int BCNT_W    = 3;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_HYPHEN  = 8'h2D;
  localparam logic [7:0] CHAR_UNDER   = 8'h5F;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  localparam logic [7:0] LEAD_CONT  = 8'h80;
  localparam logic [7:0] LEAD_TWO   = 8'hC0;
  localparam logic [7:0] LEAD_THREE = 8'hE0;
  localparam logic [7:0] LEAD_FOUR  = 8'hF0;
  localparam logic [7:0] LEAD_C2    = 8'hC2;
  localparam logic [7:0] LEAD_C3    = 8'hC3;
  localparam logic [7:0] LEAD_E2    = 8'hE2;
  localparam logic [7:0] LEAD_EF    = 8'hEF;
  localparam logic [7:0] SECOND_9F  = 8'h9F;
  localparam logic [7:0] SECOND_B8  = 8'hB8;
  localparam logic [7:0] FOLD_MAX   = 8'h9E;
  localparam logic [7:0] FOLD_SKIP  = 8'h97;

  localparam logic [2:0] SEQ_NONE  = 3'd0;
  localparam logic [2:0] SEQ_TWO   = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR  = 3'd4;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } text_item_t;

  typedef struct packed {
    logic [7:0] slug_byte;
    logic       has_byte;
    logic       end_of_slug;
  } slug_item_t;

  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [BCNT_W-1:0]         count;
    logic                      fin;
  } burst_t;

  typedef struct packed {
    logic hyphen_pending;
    logic output_started;
    logic seq_open;
  } front_status_t;

endpackage

// ===== rtl/hss_front.sv =====
module hss_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  text_valid,
  output logic                  text_ready,
  input  hss_pkg::text_item_t   text_item,
  output logic                  push,
  output hss_pkg::burst_t       burst,
  input  logic                  full,
  output hss_pkg::front_status_t status
);

  logic       hyphen_pending, hyphen_pending_next;
  logic       output_started, output_started_next;
  logic [2:0] seq_len, seq_len_next;
  logic [1:0] seq_rcv, seq_rcv_next;
  logic [7:0] seq_bytes [3];

  logic       accept;
  logic [7:0] b;
  logic       fin;
  logic       kept;
  logic [3:0][7:0] k;
  logic [2:0] klen;
  logic       wr_en;
  logic [1:0] wr_idx;
  logic [7:0] s0, s1, s2, s3;
  logic       drop;

  assign text_ready = !full;
  assign accept     = text_valid && text_ready;
  assign b          = text_item.text_byte;
  assign fin        = text_item.final_byte;

  always_comb begin
    hyphen_pending_next = hyphen_pending;
    output_started_next = output_started;
    seq_len_next        = seq_len;
    seq_rcv_next        = seq_rcv;
    kept                = 1'b0;
    k                   = '0;
    klen                = 3'd0;
    wr_en               = 1'b0;
    wr_idx              = seq_rcv;
    s0                  = seq_bytes[0];
    s1                  = (seq_len == hss_pkg::SEQ_TWO) ? b : seq_bytes[1];
    s2                  = (seq_len == hss_pkg::SEQ_THREE) ? b : seq_bytes[2];
    s3                  = b;
    drop = ((seq_len == hss_pkg::SEQ_TWO) && (s0 == hss_pkg::LEAD_C2)) ||
           ((seq_len == hss_pkg::SEQ_FOUR) && (s1 == hss_pkg::SECOND_9F)) ||
           ((seq_len == hss_pkg::SEQ_THREE) && ((s0 == hss_pkg::LEAD_E2) ||
            ((s0 == hss_pkg::LEAD_EF) && (s1 == hss_pkg::SECOND_B8))));
    if (seq_len != hss_pkg::SEQ_NONE) begin
      if (({1'b0, seq_rcv} + 3'd1) >= seq_len) begin
        k    = {s3, s2, s1, s0};
        klen = seq_len;
        if ((seq_len == hss_pkg::SEQ_TWO) && (s0 == hss_pkg::LEAD_C3) &&
            (s1 >= hss_pkg::LEAD_CONT) && (s1 <= hss_pkg::FOLD_MAX) &&
            (s1 != hss_pkg::FOLD_SKIP)) begin
          k[1] = s1 + hss_pkg::CASE_OFFSET;
        end
        kept         = !drop;
        seq_len_next = hss_pkg::SEQ_NONE;
        seq_rcv_next = 2'd0;
      end else begin
        wr_en        = 1'b1;
        seq_rcv_next = seq_rcv + 2'd1;
      end
    end else if ((b >= hss_pkg::CHAR_UPPER_A) && (b <= hss_pkg::CHAR_UPPER_Z)) begin
      kept = 1'b1;
      k[0] = b + hss_pkg::CASE_OFFSET;
      klen = 3'd1;
    end else if (((b >= hss_pkg::CHAR_LOWER_A) && (b <= hss_pkg::CHAR_LOWER_Z)) ||
                 ((b >= hss_pkg::CHAR_DIGIT_0) && (b <= hss_pkg::CHAR_DIGIT_9))) begin
      kept = 1'b1;
      k[0] = b;
      klen = 3'd1;
    end else if ((b == hss_pkg::CHAR_SPACE) || (b == hss_pkg::CHAR_HYPHEN) ||
                 (b == hss_pkg::CHAR_UNDER) || (b == hss_pkg::CHAR_TAB)) begin
      if (output_started) begin
        hyphen_pending_next = 1'b1;
      end
    end else if (b >= hss_pkg::LEAD_TWO) begin
      wr_en        = 1'b1;
      wr_idx       = 2'd0;
      seq_rcv_next = 2'd1;
      if (b >= hss_pkg::LEAD_FOUR) begin
        seq_len_next = hss_pkg::SEQ_FOUR;
      end else if (b >= hss_pkg::LEAD_THREE) begin
        seq_len_next = hss_pkg::SEQ_THREE;
      end else begin
        seq_len_next = hss_pkg::SEQ_TWO;
      end
    end else if (b >= hss_pkg::LEAD_CONT) begin
      kept = 1'b1;
      k[0] = b;
      klen = 3'd1;
    end

    burst.bytes = '0;
    burst.count = '0;
    burst.fin   = fin;
    if (kept) begin
      if (hyphen_pending) begin
        burst.bytes = {k, hss_pkg::CHAR_HYPHEN};
        burst.count = klen + 3'd1;
      end else begin
        burst.bytes = {8'h00, k};
        burst.count = klen;
      end
      hyphen_pending_next = 1'b0;
      output_started_next = 1'b1;
    end

    if (fin) begin
      hyphen_pending_next = 1'b0;
      output_started_next = 1'b0;
      seq_len_next        = hss_pkg::SEQ_NONE;
      seq_rcv_next        = 2'd0;
    end
  end

  assign push = accept && (kept || fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      hyphen_pending <= 1'b0;
      output_started <= 1'b0;
      seq_len        <= hss_pkg::SEQ_NONE;
      seq_rcv        <= 2'd0;
    end else if (accept) begin
      hyphen_pending <= hyphen_pending_next;
      output_started <= output_started_next;
      seq_len        <= seq_len_next;
      seq_rcv        <= seq_rcv_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en && (wr_idx != 2'd3)) begin
      seq_bytes[wr_idx] <= b;
    end
  end

  assign status.hyphen_pending = hyphen_pending;
  assign status.output_started = output_started;
  assign status.seq_open       = (seq_len != hss_pkg::SEQ_NONE);

endmodule

// ===== rtl/hss_queue.sv =====
module hss_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hss_pkg::burst_t push_data,
  output logic            full,
  input  logic            pop,
  output hss_pkg::burst_t head,
  output logic            not_empty
);

  hss_pkg::burst_t                mem [hss_pkg::QUEUE_DEPTH];
  logic [hss_pkg::QPTR_W-1:0]     wr_ptr;
  logic [hss_pkg::QPTR_W-1:0]     rd_ptr;
  logic [hss_pkg::QCNT_W-1:0]     fill;
  logic                           do_push;
  logic                           do_pop;

  localparam logic [hss_pkg::QPTR_W-1:0] PtrLast = hss_pkg::QPTR_W'(hss_pkg::QUEUE_DEPTH - 1);

  assign full      = (fill == hss_pkg::QCNT_W'(hss_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/hss_back.sv =====
module hss_back (
  input  logic                clk,
  input  logic                rst,
  input  hss_pkg::burst_t     head,
  input  logic                head_valid,
  output logic                pop,
  output logic                slug_valid,
  input  logic                slug_ready,
  output hss_pkg::slug_item_t slug_item
);

  hss_pkg::burst_t           cur;
  logic [hss_pkg::BCNT_W-1:0] idx;
  logic                      busy;
  logic [hss_pkg::BCNT_W-1:0] last;
  logic                      at_last;
  logic                      transfer;
  logic                      load;

  assign last     = (cur.count == '0) ? '0 : cur.count - 1'b1;
  assign at_last  = (idx == last);
  assign transfer = slug_valid && slug_ready;
  assign load     = !busy || (transfer && at_last);
  assign pop      = load && head_valid;

  assign slug_valid            = busy;
  assign slug_item.has_byte    = (cur.count != '0);
  assign slug_item.slug_byte   = (cur.count != '0) ? cur.bytes[idx] : 8'h00;
  assign slug_item.end_of_slug = cur.fin && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= head_valid;
      idx  <= '0;
    end else if (transfer) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

endmodule

// ===== rtl/heading_slug_stream.sv =====
// Channel  Direction  Handshake                Payload
// text     in         text_valid/text_ready    text_item  (text_byte, final_byte)
// slug     out        slug_valid/slug_ready    slug_item  (slug_byte, has_byte, end_of_slug)
//
// One text byte is taken per cycle while the two-entry burst queue has room.
// A kept or final byte pushes up to five slug bytes, sent one per cycle while slug_ready.
// First slug byte is registered in the burst queue, then in the back's cur register.
// rst is synchronous, active high; clears front state, queue and back.
// A slug stall backs up the queue, then drops text_ready.
module heading_slug_stream (
  input  logic                clk,
  input  logic                rst,
  input  logic                text_valid,
  output logic                text_ready,
  input  hss_pkg::text_item_t text_item,
  output logic                slug_valid,
  input  logic                slug_ready,
  output hss_pkg::slug_item_t slug_item
);

  logic                   push;
  hss_pkg::burst_t        burst;
  logic                   full;
  logic                   pop;
  hss_pkg::burst_t        head;
  logic                   head_valid;
  hss_pkg::front_status_t status;

  hss_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text_item  (text_item),
    .push       (push),
    .burst      (burst),
    .full       (full),
    .status     (status)
  );

  hss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (burst),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .not_empty (head_valid)
  );

  hss_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .slug_valid (slug_valid),
    .slug_ready (slug_ready),
    .slug_item  (slug_item)
  );

  a_bare_marker_ends: assert property (@(posedge clk) disable iff (rst)
    slug_valid && !slug_item.has_byte |-> slug_item.end_of_slug && slug_item.slug_byte == 8'h00)
    else $error("bare marker without end_of_slug");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_ready && text_item.final_byte |=>
      !status.hyphen_pending && !status.output_started && !status.seq_open)
    else $error("front state not cleared after final byte");

  a_hyphen_needs_output: assert property (@(posedge clk) disable iff (rst)
    status.hyphen_pending |-> status.output_started)
    else $error("hyphen pending before any output");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("burst pushed into full queue");

endmodule
